// File: rtl/hrse_pkg.sv
// ----------------------------------------------------------------------------
// Hex record stream encoder package
// Shared widths, character codes, the front-to-back work descriptor and the
// queue status group.
// ----------------------------------------------------------------------------
package hrse_pkg;

   localparam int POS_W       = 21;
   localparam int LEN_W       = 6;
   localparam int SEG_W       = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_F     = 8'h46;
   localparam logic [7:0] CH_LF    = 8'h0A;

   typedef struct packed {
      logic             seg_emit;
      logic [SEG_W-1:0] seg;
      logic             hdr_emit;
      logic [LEN_W-1:0] len;
      logic [15:0]      addr;
      logic [7:0]       data;
      logic             tail_emit;
      logic [7:0]       csum;
      logic             end_emit;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'd0, nib};
      end else begin
         c = 8'h37 + {4'd0, nib};
      end
      return c;
   endfunction

endpackage

// File: rtl/hrse_front.sv
// ----------------------------------------------------------------------------
// Hex record stream encoder front
// Accepts image bytes, tracks position, segment, record fill and checksum,
// and turns each byte into a descriptor of the text it causes.
// ----------------------------------------------------------------------------
module hrse_front #(
   parameter int RECORD_BYTES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [hrse_pkg::POS_W-1:0]   csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_data_byte,
   input  hrse_pkg::queue_status_type   q_status,
   output logic                         q_push,
   output hrse_pkg::desc_type           q_desc
);

   localparam int POS_W = hrse_pkg::POS_W;
   localparam int LEN_W = hrse_pkg::LEN_W;
   localparam int SEG_W = hrse_pkg::SEG_W;

   logic [POS_W-1:0] rom_length_ff, rom_length_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [SEG_W-1:0] seg_ff, seg_in;
   logic [7:0]       cs_ff, cs_in;
   logic [LEN_W-1:0] off_ff, off_in;
   logic [LEN_W-1:0] reclen_ff, reclen_in;

   logic             accept;
   logic             active;
   logic             rec_start;
   logic [POS_W-1:0] rem;
   logic [LEN_W-1:0] len;
   logic [SEG_W-1:0] seg;
   logic             pos_zero;
   logic [7:0]       base;
   logic [7:0]       cs_new;
   logic [LEN_W-1:0] off_inc;
   logic             file_end;
   logic             tail;

   always_comb begin
      req_stall = q_status.full;
      accept    = req_valid && !req_stall;
      active    = pos_ff < rom_length_ff;
      rec_start = off_ff == '0;
      pos_zero  = pos_ff == '0;
      rem       = rom_length_ff - pos_ff;
      if (rem < POS_W'(RECORD_BYTES)) begin
         len = rem[LEN_W-1:0];
      end else begin
         len = LEN_W'(RECORD_BYTES);
      end
      seg = pos_ff[16 +: SEG_W];
      if (rec_start) begin
         base = 8'({2'd0, len} + {1'b0, pos_ff[15:8]} + {1'b0, pos_ff[7:0]});
      end else begin
         base = cs_ff;
      end
      cs_new    = base + req_data_byte;
      reclen_in = rec_start ? len : reclen_ff;
      off_inc   = off_ff + 1'b1;
      file_end  = ({1'b0, pos_ff} + 1'b1) >= {1'b0, rom_length_ff};
      tail      = (off_inc >= reclen_in) || file_end;

      q_desc.seg_emit  = pos_zero || (rec_start && (seg != seg_ff));
      q_desc.seg       = seg;
      q_desc.hdr_emit  = rec_start;
      q_desc.len       = len;
      q_desc.addr      = pos_ff[15:0];
      q_desc.data      = req_data_byte;
      q_desc.tail_emit = tail;
      q_desc.csum      = 8'd0 - cs_new;
      q_desc.end_emit  = file_end;
      q_push           = accept && active;

      rom_length_in = csr_wr_en ? csr_wr_data : rom_length_ff;
      pos_in        = pos_ff + 1'b1;
      seg_in        = (pos_zero || rec_start) ? seg : seg_ff;
      cs_in         = cs_new;
      off_in        = tail ? '0 : off_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_length_ff <= POS_W'(65536);
         pos_ff        <= '0;
         seg_ff        <= '0;
         cs_ff         <= '0;
         off_ff        <= '0;
         reclen_ff     <= '0;
      end else begin
         rom_length_ff <= rom_length_in;
         if (q_push) begin
            pos_ff    <= pos_in;
            seg_ff    <= seg_in;
            cs_ff     <= cs_in;
            off_ff    <= off_in;
            reclen_ff <= reclen_in;
         end
      end
   end

endmodule

// File: rtl/hrse_queue.sv
// ----------------------------------------------------------------------------
// Hex record stream encoder queue
// A short register queue of descriptors between the front and the back.
// ----------------------------------------------------------------------------
module hrse_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  hrse_pkg::desc_type         push_desc,
   input  logic                       pop,
   output hrse_pkg::desc_type         head_desc,
   output hrse_pkg::queue_status_type status
);

   localparam int DEPTH = hrse_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   hrse_pkg::desc_type entry_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      status.full  = count_ff == CNT_W'(DEPTH);
      status.empty = count_ff == '0;
      head_desc    = entry_ff[rd_ptr_ff];
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/hrse_back.sv
// ----------------------------------------------------------------------------
// Hex record stream encoder back
// Walks each descriptor through its text phases and drives one character
// per cycle into the result register while the result is not stalled.
// ----------------------------------------------------------------------------
module hrse_back (
   input  logic                       clock,
   input  logic                       reset,
   input  hrse_pkg::desc_type         head_desc,
   input  hrse_pkg::queue_status_type q_status,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_char,
   output logic                       rsp_last_of_run,
   output logic                       rsp_file_done
);

   typedef enum logic [2:0] {
      PH_SEG,
      PH_HDR,
      PH_DATA,
      PH_TAIL,
      PH_END
   } phase_type;

   hrse_pkg::desc_type desc_ff, desc_in;
   phase_type          phase_ff, phase_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               valid_ff, valid_in;
   logic [7:0]         char_ff, char_in;
   logic               last_ff, last_in;
   logic               done_ff, done_in;

   hrse_pkg::desc_type sel;
   phase_type          sel_phase;
   phase_type          nxt_phase;
   logic [3:0]         sel_cnt;
   logic [3:0]         last_idx;
   logic               phase_last;
   logic               nxt_none;
   logic               have;
   logic               adv;
   logic [7:0]         seg_cs;
   logic [7:0]         len8;
   logic [7:0]         ch;

   always_comb begin
      adv  = !valid_ff || !rsp_stall;
      have = busy_ff || !q_status.empty;
      if (busy_ff) begin
         sel       = desc_ff;
         sel_phase = phase_ff;
         sel_cnt   = cnt_ff;
      end else begin
         sel = head_desc;
         if (head_desc.seg_emit) begin
            sel_phase = PH_SEG;
         end else if (head_desc.hdr_emit) begin
            sel_phase = PH_HDR;
         end else begin
            sel_phase = PH_DATA;
         end
         sel_cnt = '0;
      end

      seg_cs = 8'd0 - (8'd4 + {sel.seg, 4'd0});
      len8   = {2'd0, sel.len};
      nxt_none  = 1'b0;
      nxt_phase = PH_DATA;
      ch        = hrse_pkg::CH_ZERO;

      unique case (sel_phase)
         PH_SEG: begin
            last_idx  = 4'd15;
            nxt_phase = sel.hdr_emit ? PH_HDR : PH_DATA;
            case (sel_cnt)
               4'd0:    ch = hrse_pkg::CH_COLON;
               4'd2:    ch = hrse_pkg::CH_TWO;
               4'd8:    ch = hrse_pkg::CH_TWO;
               4'd9:    ch = hrse_pkg::hex_char(sel.seg);
               4'd13:   ch = hrse_pkg::hex_char(seg_cs[7:4]);
               4'd14:   ch = hrse_pkg::hex_char(seg_cs[3:0]);
               4'd15:   ch = hrse_pkg::CH_LF;
               default: ch = hrse_pkg::CH_ZERO;
            endcase
         end
         PH_HDR: begin
            last_idx  = 4'd8;
            nxt_phase = PH_DATA;
            case (sel_cnt)
               4'd0:    ch = hrse_pkg::CH_COLON;
               4'd1:    ch = hrse_pkg::hex_char(len8[7:4]);
               4'd2:    ch = hrse_pkg::hex_char(len8[3:0]);
               4'd3:    ch = hrse_pkg::hex_char(sel.addr[15:12]);
               4'd4:    ch = hrse_pkg::hex_char(sel.addr[11:8]);
               4'd5:    ch = hrse_pkg::hex_char(sel.addr[7:4]);
               4'd6:    ch = hrse_pkg::hex_char(sel.addr[3:0]);
               default: ch = hrse_pkg::CH_ZERO;
            endcase
         end
         PH_DATA: begin
            last_idx = 4'd1;
            if (sel.tail_emit) begin
               nxt_phase = PH_TAIL;
            end else if (sel.end_emit) begin
               nxt_phase = PH_END;
            end else begin
               nxt_none = 1'b1;
            end
            ch = sel_cnt[0] ? hrse_pkg::hex_char(sel.data[3:0])
                            : hrse_pkg::hex_char(sel.data[7:4]);
         end
         PH_TAIL: begin
            last_idx  = 4'd2;
            nxt_phase = PH_END;
            nxt_none  = !sel.end_emit;
            case (sel_cnt)
               4'd0:    ch = hrse_pkg::hex_char(sel.csum[7:4]);
               4'd1:    ch = hrse_pkg::hex_char(sel.csum[3:0]);
               default: ch = hrse_pkg::CH_LF;
            endcase
         end
         PH_END: begin
            last_idx = 4'd11;
            nxt_none = 1'b1;
            case (sel_cnt)
               4'd0:    ch = hrse_pkg::CH_COLON;
               4'd8:    ch = hrse_pkg::CH_ONE;
               4'd9:    ch = hrse_pkg::CH_F;
               4'd10:   ch = hrse_pkg::CH_F;
               4'd11:   ch = hrse_pkg::CH_LF;
               default: ch = hrse_pkg::CH_ZERO;
            endcase
         end
         default: begin
            last_idx = 4'd0;
            nxt_none = 1'b1;
         end
      endcase

      phase_last = sel_cnt == last_idx;
      q_pop      = adv && !busy_ff && !q_status.empty;

      desc_in  = busy_ff ? desc_ff : head_desc;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      if (adv) begin
         valid_in = have;
         if (have) begin
            char_in = ch;
            last_in = phase_last && nxt_none;
            done_in = phase_last && (sel_phase == PH_END);
            if (phase_last) begin
               busy_in  = !nxt_none;
               phase_in = nxt_phase;
               cnt_in   = '0;
            end else begin
               busy_in  = 1'b1;
               phase_in = sel_phase;
               cnt_in   = sel_cnt + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      desc_ff  <= desc_in;
      phase_ff <= phase_in;
      cnt_ff   <= cnt_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
      done_ff  <= done_in;
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_file_done   = done_ff;

endmodule

// File: rtl/hex_record_stream_encoder_unit.sv
// ----------------------------------------------------------------------------
// Hex record stream encoder unit
// Turns a byte stream of a ROM image into hex record text, one character
// per result item.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  req_data_byte
//   rsp      out        rsp_valid/rsp_stall  rsp_out_char, rsp_last_of_run,
//                                            rsp_file_done
//   csr      in         csr_wr_en            csr_wr_data (rom_length)
//
// The back end emits one character per cycle while the result is not
// stalled; an item causes two characters for a mid-record byte, up to 42
// when a segment record, header, checksum and end record all fall on it.
// An item is accepted in the cycle it arrives while the two-entry
// descriptor queue has room. Synchronous reset clears all control state and
// sets rom_length to 65536. A stalled result holds in the output register.
// ----------------------------------------------------------------------------
module hex_record_stream_encoder_unit #(
   parameter int RECORD_BYTES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [hrse_pkg::POS_W-1:0] csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_data_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_char,
   output logic                       rsp_last_of_run,
   output logic                       rsp_file_done
);

   hrse_pkg::queue_status_type q_status;
   hrse_pkg::desc_type         push_desc;
   hrse_pkg::desc_type         head_desc;
   logic                       q_push;
   logic                       q_pop;

   hrse_front #(
      .RECORD_BYTES(RECORD_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data_byte(req_data_byte),
      .q_status     (q_status),
      .q_push       (q_push),
      .q_desc       (push_desc)
   );

   hrse_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_desc(push_desc),
      .pop      (q_pop),
      .head_desc(head_desc),
      .status   (q_status)
   );

   hrse_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_desc      (head_desc),
      .q_status       (q_status),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_file_done  (rsp_file_done)
   );

endmodule

// File: dv/hex_record_stream_encoder_unit_tb.sv
// ----------------------------------------------------------------------------
// Hex record stream encoder unit testbench
// Feeds image bytes to the encoder and checks every hex text character, its
// end-of-run flag and its end-of-file flag against a built-in predictor.
// rom_length is rewritten between phases, only while the block is idle. The
// run covers files that end early and bytes that arrive after the end. It
// also covers a record that stays open while rom_length changes. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module hex_record_stream_encoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RECORD_BYTES   = 16;
   localparam int ITEM_TARGET    = 410;
   localparam int SETTLE_CYCLES  = 100;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 400;

   typedef struct packed {
      logic [7:0] ch;
      logic       last_of_run;
      logic       file_done;
   } text_char_type;

   class hex_text_checker;
      logic [hrse_pkg::POS_W-1:0] rom_len;
      logic [hrse_pkg::POS_W-1:0] byte_pos;
      logic [hrse_pkg::SEG_W-1:0] seg;
      logic [7:0]                 csum;
      logic [hrse_pkg::LEN_W-1:0] rec_off;
      logic [hrse_pkg::LEN_W-1:0] rec_len;
      text_char_type              expected_chars[$];
      int                         errors;

      function new();
         rom_len  = hrse_pkg::POS_W'(65536);
         byte_pos = '0;
         seg      = '0;
         csum     = '0;
         rec_off  = '0;
         rec_len  = '0;
         errors   = 0;
      endfunction

      function void put(input logic [7:0] c);
         text_char_type t;
         t.ch          = c;
         t.last_of_run = 1'b0;
         t.file_done   = 1'b0;
         expected_chars.push_back(t);
      endfunction

      function logic [7:0] digit(input logic [3:0] nib);
         logic [7:0] c;
         if (nib < 4'd10) begin
            c = hrse_pkg::CH_ZERO + {4'd0, nib};
         end else begin
            c = 8'h41 + {4'd0, nib} - 8'd10;
         end
         return c;
      endfunction

      function void put_hex(input logic [7:0] v);
         put(digit(v[7:4]));
         put(digit(v[3:0]));
      endfunction

      function void put_text(input string s);
         for (int i = 0; i < s.len(); i++) begin
            put(8'(s[i]));
         end
      endfunction

      function void put_segment_record(input logic [hrse_pkg::SEG_W-1:0] s);
         logic [7:0] sum;
         sum = 8'd4 + {s, 4'h0};
         put_text(":02000002");
         put(digit(s));
         put_text("000");
         put_hex(8'd0 - sum);
         put(hrse_pkg::CH_LF);
      endfunction

      // Returns 1 when the byte produced text, 0 when it fell past the end.
      function bit encode_byte(input logic [7:0] d);
         int unsigned                remain;
         int unsigned                len;
         logic [hrse_pkg::SEG_W-1:0] s;
         bit                         file_end;
         text_char_type              t;
         int                         last_idx;
         if (byte_pos >= rom_len) begin
            return 1'b0;
         end
         if (byte_pos == '0) begin
            seg = '0;
            put_segment_record('0);
         end
         if (rec_off == '0) begin
            remain = int'(rom_len) - int'(byte_pos);
            len    = (remain < RECORD_BYTES) ? remain : RECORD_BYTES;
            s      = byte_pos[19:16];
            if (s != seg) begin
               seg = s;
               put_segment_record(s);
            end
            rec_len = len[hrse_pkg::LEN_W-1:0];
            put(hrse_pkg::CH_COLON);
            put_hex(len[7:0]);
            put_hex(byte_pos[15:8]);
            put_hex(byte_pos[7:0]);
            put_text("00");
            csum = len[7:0] + byte_pos[15:8] + byte_pos[7:0];
         end
         put_hex(d);
         csum     = csum + d;
         rec_off  = rec_off + 1'b1;
         file_end = (int'(byte_pos) + 1) >= int'(rom_len);
         byte_pos = byte_pos + 1'b1;
         if (rec_off >= rec_len || file_end) begin
            put_hex(8'd0 - csum);
            put(hrse_pkg::CH_LF);
            rec_off = '0;
         end
         if (file_end) begin
            put_text(":00000001FF");
            put(hrse_pkg::CH_LF);
         end
         last_idx = expected_chars.size() - 1;
         t = expected_chars[last_idx];
         t.last_of_run = 1'b1;
         t.file_done   = file_end;
         expected_chars[last_idx] = t;
         return 1'b1;
      endfunction

      function void check_char(input logic [7:0] ch, input logic last_of_run,
                               input logic file_done);
         text_char_type t;
         if (expected_chars.size() == 0) begin
            $error("unexpected character %h with no item outstanding", ch);
            errors++;
            return;
         end
         t = expected_chars.pop_front();
         if (ch !== t.ch) begin
            $error("out_char: expected %h, got %h", t.ch, ch);
            errors++;
         end
         if (last_of_run !== t.last_of_run) begin
            $error("last_of_run: expected %b, got %b", t.last_of_run, last_of_run);
            errors++;
         end
         if (file_done !== t.file_done) begin
            $error("file_done: expected %b, got %b", t.file_done, file_done);
            errors++;
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [hrse_pkg::POS_W-1:0] csr_wr_data;
   logic                       req_valid;
   logic                       req_stall;
   logic [7:0]                 req_data_byte;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [7:0]                 rsp_out_char;
   logic                       rsp_last_of_run;
   logic                       rsp_file_done;

   hex_text_checker    sb;
   bit                 tx_gaps_on;
   bit                 rx_gaps_on;
   int                 rx_hold_req;
   int                 quiet_cycles;

   hex_record_stream_encoder_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_file_done   (rsp_file_done)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end else if (r < 99) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic send_byte(input logic [7:0] d, output bit caused);
      int gap;
      gap = tx_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= d;
      do @(posedge clock); while (req_stall);
      caused = sb.encode_byte(d);
      @(negedge clock);
   endtask

   task automatic send_random(input int n, inout int items);
      bit c;
      repeat (n) begin
         send_byte(8'($urandom_range(0, 255)), c);
         items += int'(c);
      end
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (sb.expected_chars.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_rom_length(input logic [hrse_pkg::POS_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.rom_len   = v;
      @(negedge clock);
   endtask

   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_req > 0) begin
            hold_left   = rx_hold_req;
            rx_hold_req = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (rx_gaps_on && $urandom_range(0, 7) == 0) begin
               stall_left = 1 + pick_gap();
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_char(rsp_out_char, rsp_last_of_run, rsp_file_done);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** hex_record_stream_encoder_unit: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      logic [7:0]                 pattern[16];
      logic [hrse_pkg::POS_W-1:0] pos;
      logic [hrse_pkg::POS_W-1:0] new_len;
      int                         items;
      int                         n;
      int                         sel;
      int                         phase;
      bit                         c;
      pattern = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h7F,
                  8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'hAA};
      items         = 0;
      phase         = 0;
      quiet_cycles  = 0;
      rx_hold_req   = 0;
      tx_gaps_on    = 1'b1;
      rx_gaps_on    = 1'b1;
      sb            = new();
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_valid     = 1'b0;
      req_data_byte = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // One-byte file, then bytes that arrive after the end.
      write_rom_length(hrse_pkg::POS_W'(1));
      send_byte(8'h00, c);
      items += int'(c);
      send_byte(8'hFF, c);
      send_byte(8'h5A, c);
      drain_and_settle();
      write_rom_length('0);
      send_byte(8'h11, c);
      drain_and_settle();
      write_rom_length(hrse_pkg::POS_W'(3));
      send_byte(8'hFF, c);
      items += int'(c);
      send_byte(8'h80, c);
      items += int'(c);
      drain_and_settle();
      write_rom_length(hrse_pkg::POS_W'(19));
      foreach (pattern[i]) begin
         send_byte(pattern[i], c);
         items += int'(c);
      end
      drain_and_settle();

      // The length changes while a record is open, first below the position.
      write_rom_length(hrse_pkg::POS_W'(40));
      send_random(4, items);
      drain_and_settle();
      write_rom_length(hrse_pkg::POS_W'(20));
      send_byte(8'h33, c);
      drain_and_settle();
      write_rom_length(hrse_pkg::POS_W'(26));
      send_random(3, items);

      while (items < ITEM_TARGET) begin
         drain_and_settle();
         tx_gaps_on = ($urandom_range(0, 3) != 0);
         rx_gaps_on = ($urandom_range(0, 3) != 0);
         pos = sb.byte_pos;
         sel = (phase == 3) ? 1 : $urandom_range(0, 9);
         if (sel == 0) begin
            new_len = pos - hrse_pkg::POS_W'($urandom_range(1, 5));
            n = $urandom_range(1, 3);
         end else begin
            new_len = pos + hrse_pkg::POS_W'((sel == 1) ? $urandom_range(60, 150) :
                                                          $urandom_range(1, 40));
            n = $urandom_range(1, int'(new_len - pos) + 3);
         end
         write_rom_length(new_len);
         if (phase == 3) begin
            tx_gaps_on  = 1'b0;
            rx_hold_req = LONG_HOLD;
            n = (n < 12) ? 12 : n;
         end
         send_random(n, items);
         phase++;
      end

      drain_and_settle();
      if (sb.errors == 0) begin
         $display("** hex_record_stream_encoder_unit: PASSED **");
      end else begin
         $display("** hex_record_stream_encoder_unit: FAILED **");
      end
      $finish;
   end

endmodule
